// ===== src/huid_pkg.sv =====
// Shared types, sizes and the bucket hash for the unique-id interner.
package huid_pkg;

    // Table geometry; bucket count is a power of two so the hash reduces by mask
    localparam int BKT_BITS  = 9;
    localparam int BUCKETS   = 1 << BKT_BITS;
    localparam int WAYS      = 8;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FILL_BITS = $clog2(WAYS + 1);

    // Field widths
    localparam int ID_BITS     = 56;
    localparam int PATH_BITS   = 64;
    localparam int KIND_BITS   = 8;
    localparam int POS_BITS    = 16;

    // Hash multipliers
    localparam int HASH_MUL_PARENT = 333;
    localparam int HASH_MUL_OBJECT = 7;

    // Id counter value after reset (ids handed out start one above it) and the last usable id
    localparam logic [ID_BITS-1:0] ID_RESET = ID_BITS'(12);
    localparam logic [ID_BITS-1:0] ID_MAX   = '1;

    typedef logic [BKT_BITS-1:0]  bkt_t;
    typedef logic [WAY_BITS-1:0]  way_t;
    typedef logic [FILL_BITS-1:0] fill_t;

    // One stored entry: key plus its assigned id
    typedef struct packed {
        logic [ID_BITS-1:0]   uid;
        logic [PATH_BITS-1:0] parent;
        logic [PATH_BITS-1:0] object;
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  pos;
    } slot_t;

    typedef slot_t [WAYS-1:0] row_t;

    // Write request from the control logic to the table memories
    typedef struct packed {
        logic  slot_we;
        logic  fill_we;
        bkt_t  bkt;
        way_t  way;
        slot_t slot;
        fill_t fill;
    } store_wr_t;

    // Bucket hash: low bits of parent*333 + object*7 + kind, taken mod 2^BKT_BITS
    function automatic bkt_t bucket_of(input logic [PATH_BITS-1:0] parent,
                                       input logic [PATH_BITS-1:0] object,
                                       input logic [KIND_BITS-1:0] kind);
        bkt_t p;
        bkt_t o;
        bkt_t k;
        p = parent[BKT_BITS-1:0];
        o = object[BKT_BITS-1:0];
        k = BKT_BITS'(kind);
        return p * BKT_BITS'(HASH_MUL_PARENT) + o * BKT_BITS'(HASH_MUL_OBJECT) + k;
    endfunction

endpackage

// ===== src/hashed_unique_id_interner_unit.sv =====
// Top level of the hashed unique-id interner.
// Each input transaction carries a key (parent path, object id, kind, entry index) and
// yields one result transaction: the unique id shifted left 8 bits and ORed with the
// kind, flagged as new or found. Keys hash to one of 512 buckets of 8 ways; a miss on a
// full bucket or with the id counter exhausted returns 0 with overflow set and stores
// nothing. The accept cycle reads the bucket row and fill count from the table
// memories; the lookup state compares every way in use at once and writes a new entry
// back once the output is free. After reset a clearing pass zeroes the fill counts of
// all 512 buckets, one bucket per cycle; no input is taken until it ends. A finished
// result is held in an output register, so the next input is taken while it waits.
module hashed_unique_id_interner_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // parent_path[63:0], object_id[127:64], entry_index[143:128]
    input  logic [7:0]   s_tuser,  // kind[7:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // unique_path[63:0]
    output logic [7:0]   m_tuser   // is_new[0], overflow[1], zero[7:2]
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    huid_pkg::bkt_t               clr_cnt_reg, clr_cnt_next;
    logic [huid_pkg::ID_BITS-1:0] id_reg, id_next;
    huid_pkg::slot_t              key_reg;
    huid_pkg::bkt_t               bkt_reg;
    logic                         m_tvalid_reg;
    logic [63:0]                  m_tdata_reg, m_tdata_next;
    logic [1:0]                   m_tuser_reg, m_tuser_next;

    logic                         accept;
    logic                         out_free;
    logic                         commit;
    huid_pkg::bkt_t               rd_bkt;
    huid_pkg::row_t               row;
    huid_pkg::fill_t              fill;
    huid_pkg::store_wr_t          wr;
    logic                         any_hit;
    logic [huid_pkg::ID_BITS-1:0] hit_id;
    logic                         no_room;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_LOOKUP) && out_free;
    assign rd_bkt   = huid_pkg::bucket_of(s_tdata[63:0], s_tdata[127:64], s_tuser);

    huid_store u_store (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_bkt   (rd_bkt),
        .row_reg  (row),
        .fill_reg (fill),
        .wr       (wr)
    );

    // Compare every way in use against the key; lowest matching way wins
    always_comb begin
        any_hit = 1'b0;
        hit_id  = '0;
        for (int w = huid_pkg::WAYS - 1; w >= 0; w--) begin
            if ((huid_pkg::FILL_BITS'(w) < fill) &&
                row[w].parent == key_reg.parent && row[w].object == key_reg.object &&
                row[w].kind == key_reg.kind && row[w].pos == key_reg.pos) begin
                any_hit = 1'b1;
                hit_id  = row[w].uid;
            end
        end
    end

    assign no_room = (fill == huid_pkg::FILL_BITS'(huid_pkg::WAYS)) ||
                     (id_reg == huid_pkg::ID_MAX);

    // Result, id allocation and table write-back
    always_comb begin
        id_next      = id_reg;
        m_tdata_next = '0;
        m_tuser_next = '0;
        wr           = '0;
        wr.bkt       = bkt_reg;
        wr.way       = huid_pkg::WAY_BITS'(fill);
        wr.slot      = key_reg;
        wr.fill      = fill + huid_pkg::FILL_BITS'(1);
        if (state_reg == ST_CLEAR) begin
            wr.fill_we = 1'b1;
            wr.bkt     = clr_cnt_reg;
            wr.fill    = '0;
        end else if (any_hit) begin
            m_tdata_next = {hit_id, key_reg.kind};
        end else if (no_room) begin
            m_tuser_next = 2'b10;
        end else begin
            id_next      = id_reg + huid_pkg::ID_BITS'(1);
            m_tdata_next = {id_next, key_reg.kind};
            m_tuser_next = 2'b01;
            wr.slot.uid  = id_next;
            wr.slot_we   = commit;
            wr.fill_we   = commit;
        end
    end

    // Sequencer: clear pass, then accept / lookup alternation
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + huid_pkg::BKT_BITS'(1);
                if (clr_cnt_reg == huid_pkg::BKT_BITS'(huid_pkg::BUCKETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            id_reg       <= huid_pkg::ID_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (commit) begin
                id_reg       <= id_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Key capture and output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg.uid    <= '0;
            key_reg.parent <= s_tdata[63:0];
            key_reg.object <= s_tdata[127:64];
            key_reg.kind   <= s_tuser;
            key_reg.pos    <= s_tdata[143:128];
            bkt_reg        <= rd_bkt;
        end
        if (commit) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {6'b0, m_tuser_reg};

endmodule

// ===== src/huid_store.sv =====
// Bucket table memories: entry rows and per-bucket fill counts, registered read.
module huid_store (
    input  logic                aclk,
    input  logic                rd_en,
    input  huid_pkg::bkt_t      rd_bkt,
    output huid_pkg::row_t      row_reg,
    output huid_pkg::fill_t     fill_reg,
    input  huid_pkg::store_wr_t wr
);

    huid_pkg::row_t  slot_mem [huid_pkg::BUCKETS];
    huid_pkg::fill_t fill_mem [huid_pkg::BUCKETS];

    // Entry memory: write one way of a row, read a whole row
    always_ff @(posedge aclk) begin
        if (wr.slot_we) begin
            slot_mem[wr.bkt][wr.way] <= wr.slot;
        end
        if (rd_en) begin
            row_reg <= slot_mem[rd_bkt];
        end
    end

    // Fill count memory
    always_ff @(posedge aclk) begin
        if (wr.fill_we) begin
            fill_mem[wr.bkt] <= wr.fill;
        end
        if (rd_en) begin
            fill_reg <= fill_mem[rd_bkt];
        end
    end

endmodule
